/* src/rbd_pkg.sv */
package rbd_pkg;

	// Default number of byte entries in the ring.
	localparam int unsigned DEPTH_DEF = 256;

	// Fixed field widths of the request and response.
	localparam int unsigned REQ_W  = 2;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned FILL_W = 9;

	// Request codes. The remaining code is a no-op.
	localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TOGGLE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

	// Response status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             side;
		logic [7:0]       byte_in;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [7:0]        byte_out;
		logic [FILL_W-1:0] fill;
	} rsp_t;

endpackage

/* src/reversible_byte_deque.sv */
// A request is held in stage one and then in the output register, where its response waits
// to be taken; a stalled response holds the request behind it in stage one.
// Throughput: one request per cycle while the response path is not stalled; the single-port ring
// memory takes one write or one read per request, and its read data is registered with stage one.
// Reset (arst_n low, asynchronous): pointers, count, reversal flag and all valid flags clear.
// The ring memory itself is not cleared; entries are only read after a push wrote them.
module reversible_byte_deque #(
	parameter int unsigned DEPTH = rbd_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rbd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rbd_pkg::rsp_t rsp
);

	// Index width of the ring, width of the held count (it must reach DEPTH itself),
	// and width of the head-plus-count sum used to find the physical back.
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = CW + 1;

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

	// Architectural state. The head pointer is the physical front; the physical
	// back sits at head + count - 1 modulo DEPTH.
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic          rev_q, rev_d;

	// Ring memory with one synchronous port: one write or one read per request.
	logic [7:0]    mem [DEPTH];
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0]    rd_q;

	// Stage one: the request has updated the state and, for a pop, the memory
	// read is in flight. The response is completed once the read data is back.
	logic                      s1_valid_q;
	logic                      s1_pop_ok_s1;
	logic [rbd_pkg::STAT_W-1:0] s1_status_s1, status_d;
	logic [rbd_pkg::FILL_W-1:0] s1_fill_s1;

	// Output register.
	logic          rsp_valid_q;
	rbd_pkg::rsp_t rsp_q;

	logic accept, s1_move, pop_ok_d;

	// Physical back address, the slot just past it and the slot just before the head, all wrapped into the ring.
	logic [SW-1:0] tail_sum, last_sum;
	logic [AW-1:0] next_tail_ix, back_ix, front_dec_ix;

	// The first stage moves on when the output register is empty or being emptied.
	assign s1_move   = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && !s1_move;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		tail_sum     = SW'(head_q) + SW'(count_q);
		last_sum     = tail_sum - SW'(1);
		next_tail_ix = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
		back_ix      = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);
		front_dec_ix = (head_q == '0) ? LAST_IX : head_q - AW'(1);
	end

	// Request decode: next state, memory access and the response status.
	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		rev_d    = rev_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = head_q;
		status_d = rbd_pkg::ST_OK;
		pop_ok_d = 1'b0;
		if (accept) begin
			case (req.req_type)
				rbd_pkg::REQ_PUSH: begin
					if (count_q >= DEPTH_C) begin
						status_d = rbd_pkg::ST_FULL;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + CW'(1);
						// While reversed, the logical front is the physical back.
						if (req.side == rev_q) begin
							head_d   = front_dec_ix;
							mem_addr = front_dec_ix;
						end else begin
							mem_addr = next_tail_ix;
						end
					end
				end
				rbd_pkg::REQ_TOGGLE: begin
					rev_d = !rev_q;
				end
				rbd_pkg::REQ_POP: begin
					if (count_q == '0) begin
						status_d = rbd_pkg::ST_EMPTY;
					end else begin
						mem_re   = 1'b1;
						pop_ok_d = 1'b1;
						count_d  = count_q - CW'(1);
						if (rev_q) begin
							mem_addr = back_ix;
						end else begin
							mem_addr = head_q;
							head_d   = (head_q == LAST_IX) ? '0 : head_q + AW'(1);
						end
					end
				end
				default: begin
					// Unused code: the state is left as it is.
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= req.byte_in;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			rev_q       <= 1'b0;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			rev_q   <= rev_d;
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_status_s1 <= status_d;
			s1_pop_ok_s1 <= pop_ok_d;
			s1_fill_s1   <= rbd_pkg::FILL_W'(count_d);
		end
		if (s1_move) begin
			rsp_q.status   <= s1_status_s1;
			rsp_q.byte_out <= s1_pop_ok_s1 ? rd_q : 8'd0;
			rsp_q.fill     <= s1_fill_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// The held count never goes beyond the ring size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("held count exceeds ring depth");

	// A pop on an empty ring is reported as such and leaves the count alone.
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == rbd_pkg::REQ_POP && count_q == '0
		|=> s1_status_s1 == rbd_pkg::ST_EMPTY && count_q == '0)
		else $error("pop on empty ring not flagged");

	// A push on a full ring is dropped.
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == rbd_pkg::REQ_PUSH && count_q == DEPTH_C
		|=> s1_status_s1 == rbd_pkg::ST_FULL && count_q == DEPTH_C)
		else $error("push on full ring not dropped");

	// A failed request never carries a byte.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != rbd_pkg::ST_OK |-> rsp_q.byte_out == 8'd0)
		else $error("error response carries data");

	// Requests are held off only while the first stage cannot drain.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> s1_valid_q && rsp_valid_q && rsp_stall)
		else $error("request stalled without a blocked response");
`endif

endmodule
